### hw/rtl/rbse_pkg.sv
// Shared types, constants and helper functions for the breathing LED symbol encoder.
// No dependencies; every other file imports this package.
package rbse_pkg;

  localparam int FRAME_SYMBOLS = 24;
  localparam int SYM_IDX_W     = $clog2(FRAME_SYMBOLS);
  localparam logic [SYM_IDX_W-1:0] SYM_LAST = SYM_IDX_W'(FRAME_SYMBOLS - 1);

  localparam int TICK_W  = 16;
  localparam int CHAN_W  = 8;
  localparam int FRAME_W = 3 * CHAN_W;

  // Frame queue between front and back; depth must be a power of two.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BRIGHT = 2'd0,
    CFG_ONE_PAT    = 2'd1,
    CFG_ZERO_PAT   = 2'd2
  } cfg_idx_t;

  localparam logic [CHAN_W-1:0] MAX_BRIGHT_RST = 8'd255;
  localparam logic [CHAN_W-1:0] ONE_PAT_RST    = 8'd248;
  localparam logic [CHAN_W-1:0] ZERO_PAT_RST   = 8'd192;

  // Color wheel segment boundaries
  localparam logic [CHAN_W-1:0] WHEEL_SEG1 = 8'd85;
  localparam logic [CHAN_W-1:0] WHEEL_SEG2 = 8'd170;
  localparam logic [CHAN_W+1:0] WHEEL_OFS1 = 10'd255;
  localparam logic [CHAN_W+1:0] WHEEL_OFS2 = 10'd510;

  typedef struct packed {
    logic [CHAN_W-1:0] max_bright;
    logic [CHAN_W-1:0] one_pat;
    logic [CHAN_W-1:0] zero_pat;
  } cfg_regs_t;

  typedef struct packed {
    logic               vld;
    logic [FRAME_W-1:0] bits;
  } frame_req_t;

  // Exact floor(x / 255) for any product of two 8-bit values.
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
    logic [2*CHAN_W:0] s;
    s = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[2*CHAN_W-1:CHAN_W]} + 17'd1;
    return s[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

### hw/rtl/rbse_front.sv
// Front end: takes tick requests, builds the envelope and color wheel, and
// produces the 24-bit GRB frame through a four-stage pipeline. Uses rbse_pkg.
module rbse_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [rbse_pkg::TICK_W-1:0] in_tick,
  input  logic [rbse_pkg::CHAN_W-1:0] max_bright,
  input  logic                       credit_ret,
  output rbse_pkg::frame_req_t       frame_o
);
  import rbse_pkg::*;

  logic                  accept;
  logic [FIFO_CNT_W-1:0] credits_r, credits_nxt;

  logic [CHAN_W-1:0] tri_w, phase_w, m_w, r_w, g_w, b_w;
  logic [CHAN_W+1:0] p3_w;

  logic              s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [CHAN_W-1:0] s1_tri_r, s1_r_r, s1_g_r, s1_b_r;
  logic [2*CHAN_W-1:0] s2_env_prod_r;
  logic [CHAN_W-1:0] s2_r_r, s2_g_r, s2_b_r;
  logic [CHAN_W-1:0] s3_env_r, s3_r_r, s3_g_r, s3_b_r;
  logic [2*CHAN_W-1:0] s4_r_r, s4_g_r, s4_b_r;

  // One credit per free queue slot; a request reserves its slot on entry.
  assign in_full     = !rst_n || (credits_r == '0);
  assign accept      = in_push && !in_full;
  assign credits_nxt = credits_r - FIFO_CNT_W'(accept) + FIFO_CNT_W'(credit_ret);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credits_r <= FIFO_CNT_W'(FIFO_DEPTH);
    end else begin
      credits_r <= credits_nxt;
    end
  end

  // Triangle on the low nine bits: the falling half is 511 - t = ~t[7:0].
  assign tri_w   = in_tick[8] ? ~in_tick[7:0] : in_tick[7:0];
  assign phase_w = in_tick[9:2];
  assign p3_w    = {2'b00, phase_w} + {1'b0, phase_w, 1'b0};

  always_comb begin
    m_w = '0;
    r_w = '0;
    g_w = '0;
    b_w = '0;
    priority if (phase_w < WHEEL_SEG1) begin
      m_w = p3_w[CHAN_W-1:0];
      r_w = 8'd255 - m_w;
      g_w = m_w;
    end else if (phase_w < WHEEL_SEG2) begin
      m_w = CHAN_W'(p3_w - WHEEL_OFS1);
      g_w = 8'd255 - m_w;
      b_w = m_w;
    end else begin
      m_w = CHAN_W'(p3_w - WHEEL_OFS2);
      r_w = m_w;
      b_w = 8'd255 - m_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_tri_r      <= tri_w;
    s1_r_r        <= r_w;
    s1_g_r        <= g_w;
    s1_b_r        <= b_w;
    s2_env_prod_r <= s1_tri_r * max_bright;
    s2_r_r        <= s1_r_r;
    s2_g_r        <= s1_g_r;
    s2_b_r        <= s1_b_r;
    s3_env_r      <= div255(s2_env_prod_r);
    s3_r_r        <= s2_r_r;
    s3_g_r        <= s2_g_r;
    s3_b_r        <= s2_b_r;
    s4_r_r        <= s3_r_r * s3_env_r;
    s4_g_r        <= s3_g_r * s3_env_r;
    s4_b_r        <= s3_b_r * s3_env_r;
  end

  assign frame_o.vld  = s4_vld_r;
  assign frame_o.bits = {div255(s4_g_r), div255(s4_r_r), div255(s4_b_r)};

endmodule

### hw/rtl/rbse_fifo.sv
// Short frame queue between front and back ends. Overflow is prevented by
// the front end's credit count. Uses rbse_pkg.
module rbse_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rbse_pkg::frame_req_t         frame_i,
  input  logic                         pop,
  output logic                         empty,
  output logic [rbse_pkg::FRAME_W-1:0] rd_data
);
  import rbse_pkg::*;

  logic [FRAME_W-1:0]    mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign empty     = (count_r == '0);
  assign rd_data   = mem_r[rd_ptr_r];
  assign count_nxt = count_r + FIFO_CNT_W'(frame_i.vld) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (frame_i.vld) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_i.vld) begin
      mem_r[wr_ptr_r] <= frame_i.bits;
    end
  end

endmodule

### hw/rtl/rbse_back.sv
// Back end: shifts a queued frame out MSB first, one link symbol per request.
// Uses rbse_pkg.
module rbse_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fifo_empty,
  input  logic [rbse_pkg::FRAME_W-1:0]  fifo_data,
  output logic                          fifo_pop,
  input  logic [rbse_pkg::CHAN_W-1:0]   one_pat,
  input  logic [rbse_pkg::CHAN_W-1:0]   zero_pat,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic [rbse_pkg::CHAN_W-1:0]   out_symbol,
  output logic                          out_last
);
  import rbse_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [SYM_IDX_W-1:0] idx_r, idx_nxt;
  logic [FRAME_W-1:0]   bits_r, bits_nxt;
  logic                 take, done, load;

  assign out_empty = !busy_r;
  assign take      = out_pop && busy_r;
  assign done      = take && (idx_r == SYM_LAST);
  assign load      = !fifo_empty && (!busy_r || done);
  assign fifo_pop  = load;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    bits_nxt = bits_r;
    priority if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      bits_nxt = fifo_data;
    end else if (done) begin
      busy_nxt = 1'b0;
      idx_nxt  = '0;
    end else if (take) begin
      idx_nxt  = idx_r + 1'b1;
      bits_nxt = {bits_r[FRAME_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
  end

  assign out_symbol = bits_r[FRAME_W-1] ? {1'b0, one_pat[CHAN_W-1:1]}
                                        : {1'b0, zero_pat[CHAN_W-1:1]};
  assign out_last   = busy_r && (idx_r == SYM_LAST);

endmodule

### hw/rtl/rgb_breath_led_symbol_encoder_top.sv
// Each frame passes the front-end stages, the frame queue and then the shifter.
// Each tick gives 24 symbols, one per cycle while popped and while frames wait.
// Up to four ticks are taken back to back; the four-entry frame queue sets that.
// Reset (synchronous, rst_n low): queue and shifter empty, registers to defaults.
// Depends on rbse_pkg, rbse_front, rbse_fifo and rbse_back.
module rgb_breath_led_symbol_encoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [rbse_pkg::TICK_W-1:0]    in_tick,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [rbse_pkg::CHAN_W-1:0]    out_symbol,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [rbse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbse_pkg::CHAN_W-1:0]    cfg_data
);
  import rbse_pkg::*;

  cfg_regs_t          cfg_r, cfg_nxt;
  frame_req_t         frame;
  logic               fifo_empty, fifo_pop;
  logic [FRAME_W-1:0] fifo_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_BRIGHT: cfg_nxt.max_bright = cfg_data;
        CFG_ONE_PAT:    cfg_nxt.one_pat    = cfg_data;
        CFG_ZERO_PAT:   cfg_nxt.zero_pat   = cfg_data;
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_bright <= MAX_BRIGHT_RST;
      cfg_r.one_pat    <= ONE_PAT_RST;
      cfg_r.zero_pat   <= ZERO_PAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rbse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_tick    (in_tick),
    .max_bright (cfg_r.max_bright),
    .credit_ret (fifo_pop),
    .frame_o    (frame)
  );

  rbse_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .frame_i (frame),
    .pop     (fifo_pop),
    .empty   (fifo_empty),
    .rd_data (fifo_data)
  );

  rbse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_data  (fifo_data),
    .fifo_pop   (fifo_pop),
    .one_pat    (cfg_r.one_pat),
    .zero_pat   (cfg_r.zero_pat),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

endmodule

### hw/rtl/rbse_checker.sv
// Port-level checks for the breathing LED symbol encoder, bound to the top level.
// Uses rbse_pkg.
module rbse_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_full,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic [rbse_pkg::CHAN_W-1:0]    out_symbol,
  input logic                           out_last,
  input logic                           cfg_we
);
  import rbse_pkg::*;

  // Leaving reset: nothing to send, room for requests.
  a_reset_state: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> (out_empty && !in_full))
    else $error("not empty or full right after reset");

  // A waiting symbol holds until taken, unless a register is written.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop && !cfg_we) |=>
      (!out_empty && $stable(out_symbol) && $stable(out_last)))
    else $error("waiting symbol changed");

  // Within a frame the next symbol is ready at once.
  a_frame_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last) |=> !out_empty)
    else $error("gap inside a frame");

  // A frame boundary is never followed by another last symbol.
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && out_last) |=> !out_last)
    else $error("two last symbols in a row");

endmodule

bind rgb_breath_led_symbol_encoder_top rbse_checker u_rbse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_full    (in_full),
  .out_empty  (out_empty),
  .out_pop    (out_pop),
  .out_symbol (out_symbol),
  .out_last   (out_last),
  .cfg_we     (cfg_we)
);

### tb/sv/rgb_breath_led_symbol_encoder_top_tb.sv
// Self-checking testbench for rgb_breath_led_symbol_encoder_top: ticks in, 24 link symbols out.
// A small scoreboard class predicts each frame; plain tasks drive ticks and register writes.
// Depends on rbse_pkg and the encoder RTL.
`timescale 1ns / 100ps

module rgb_breath_led_symbol_encoder_top_tb;
  import rbse_pkg::*;

  localparam int                   CYCLE_LIMIT   = 200000;
  localparam int                   SETTLE_CYCLES = 12;
  localparam int                   RANDOM_TICKS  = 44;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;  // not in the register map

  // Predicts the symbol stream of each tick and checks what the encoder emits.
  class led_frame_scoreboard;
    logic [CHAN_W-1:0] max_bright;
    logic [CHAN_W-1:0] one_pat;
    logic [CHAN_W-1:0] zero_pat;
    logic [CHAN_W-1:0] symbol_q[$];
    bit                last_q[$];
    int unsigned       mismatches;

    function new();
      max_bright = MAX_BRIGHT_RST;
      one_pat    = ONE_PAT_RST;
      zero_pat   = ZERO_PAT_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CHAN_W-1:0] value);
      case (idx)
        CFG_MAX_BRIGHT: max_bright = value;
        CFG_ONE_PAT:    one_pat    = value;
        CFG_ZERO_PAT:   zero_pat   = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return symbol_q.size();
    endfunction

    // Builds the green-red-blue word for one tick and queues its 24 symbols.
    function void encode_frame(logic [TICK_W-1:0] tick);
      int unsigned       ramp;
      int unsigned       env;
      int unsigned       phase;
      int unsigned       r;
      int unsigned       g;
      int unsigned       b;
      logic [FRAME_W-1:0] grb;
      logic [CHAN_W-1:0]  pat;
      ramp  = (tick[8:0] <= 9'd255) ? tick[8:0] : 511 - tick[8:0];
      env   = ramp * max_bright / 255;
      phase = tick[9:2];
      if (phase < 85) begin
        r = 255 - 3 * phase;
        g = 3 * phase;
        b = 0;
      end else if (phase < 170) begin
        r = 0;
        g = 255 - 3 * (phase - 85);
        b = 3 * (phase - 85);
      end else begin
        r = 3 * (phase - 170);
        g = 0;
        b = 255 - 3 * (phase - 170);
      end
      r   = r * env / 255;
      g   = g * env / 255;
      b   = b * env / 255;
      grb = {g[7:0], r[7:0], b[7:0]};
      for (int k = FRAME_W - 1; k >= 0; k--) begin
        pat = grb[k] ? one_pat : zero_pat;
        symbol_q.push_back(pat >> 1);
        last_q.push_back(k == 0);
      end
    endfunction

    task report(string msg);
      $display("[%0t] ERROR %s", $time, msg);
      mismatches++;
    endtask

    task check_symbol(logic [CHAN_W-1:0] symbol, logic last);
      logic [CHAN_W-1:0] exp_symbol;
      bit                exp_last;
      if (symbol_q.size() == 0) begin
        report($sformatf("unexpected symbol %02h last %0b", symbol, last));
      end else begin
        exp_symbol = symbol_q.pop_front();
        exp_last   = last_q.pop_front();
        if (symbol !== exp_symbol)
          report($sformatf("symbol %02h, expected %02h", symbol, exp_symbol));
        if (last !== exp_last)
          report($sformatf("last %0b, expected %0b", last, exp_last));
      end
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  logic                 in_full;
  logic [TICK_W-1:0]    in_tick   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  logic [CHAN_W-1:0]    out_symbol;
  logic                 out_last;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CHAN_W-1:0]    cfg_data  = '0;

  led_frame_scoreboard frames;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  cycle_count   = 0;

  // Wheel segment edges, envelope peak and fold, and high tick bits.
  logic [TICK_W-1:0] corner_ticks [14] = '{
    16'd0, 16'd255, 16'd256, 16'd511, 16'd128, 16'd336, 16'd340,
    16'd676, 16'd680, 16'd1020, 16'hFFFF, 16'hFCFF, 16'hAAAA, 16'h5555
  };

  rgb_breath_led_symbol_encoder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_tick    (in_tick),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task send_tick(logic [TICK_W-1:0] tick);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_tick <= tick;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    frames.encode_frame(tick);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CHAN_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    frames.write_reg(idx, value);
  endtask

  // Stop requesting and let the encoder run dry before touching registers.
  task settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] pick_reg_value();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  // Result side: decide pop at the falling edge, check at the rising edge.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (out_pop && !out_empty) frames.check_symbol(out_symbol, out_last);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    frames = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults first
    foreach (corner_ticks[i]) send_tick(corner_ticks[i]);
    settle();

    // Zero brightness: every symbol is the zero pattern
    write_reg(CFG_MAX_BRIGHT, 8'd0);
    write_reg(CFG_ONE_PAT, 8'h00);
    write_reg(CFG_ZERO_PAT, 8'hFF);
    send_tick(16'd255);
    send_tick(16'd340);
    settle();

    // A write to the spare index must leave the registers alone
    write_reg(CFG_MAX_BRIGHT, 8'd128);
    write_reg(CFG_ONE_PAT, 8'hFF);
    write_reg(CFG_ZERO_PAT, 8'h01);
    write_reg(CFG_SPARE_IDX, 8'hA5);
    send_tick(16'd255);
    send_tick(16'h5A5A);
    send_tick(16'd700);
    settle();

    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      case (phase_no)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(CFG_MAX_BRIGHT, pick_reg_value());
      write_reg(CFG_ONE_PAT, pick_reg_value());
      write_reg(CFG_ZERO_PAT, pick_reg_value());
      if ($urandom_range(1)) write_reg(CFG_SPARE_IDX, pick_reg_value());
      repeat (RANDOM_TICKS) send_tick(TICK_W'($urandom_range(65535)));
      settle();
    end

    if (frames.pending() != 0)
      frames.report($sformatf("%0d symbols never arrived", frames.pending()));
    if (frames.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
